[hw/rtl/tws_pkg.sv]
package tws_pkg;

  localparam int TexSizeDef = 64;
  localparam int MaxRowsDef = 1024;
  localparam int NumTextures = 4;
  localparam int TexSelW = 2;

  localparam int ScreenHeightRst = 480;
  localparam int ProjectionRst = 36325376;

  localparam logic [1:0] SideHoriz = 2'd1;
  localparam logic [1:0] SideVert = 2'd2;

  localparam logic [1:0] TexNorth = 2'd0;
  localparam logic [1:0] TexSouth = 2'd1;
  localparam logic [1:0] TexEast = 2'd2;
  localparam logic [1:0] TexWest = 2'd3;

  typedef enum logic [1:0] {
    RegScreenHeight = 2'd0,
    RegProjection   = 2'd1,
    RegTopColour    = 2'd2,
    RegBottomColour = 2'd3
  } tws_reg_e;

  typedef enum logic [1:0] {
    PixTop    = 2'd0,
    PixBottom = 2'd1,
    PixTexel  = 2'd2,
    PixBlack  = 2'd3
  } tws_pix_e;

  typedef struct packed {
    logic        func;
    logic [1:0]  texture_select;
    logic [11:0] texel_address;
    logic [31:0] texel_colour;
    logic [9:0]  pixel_row;
    logic [9:0]  pixel_column;
    logic [31:0] wall_distance;
    logic [1:0]  hit_side;
    logic        facing_positive;
    logic [15:0] hit_coordinate;
  } tws_in_t;

  typedef struct packed {
    logic [9:0]  out_row;
    logic [9:0]  out_column;
    logic [31:0] pixel_colour;
  } tws_out_t;

  typedef struct packed {
    tws_pix_e         kind;
    logic             keep;
    logic [TexSelW-1:0] tex_sel;
  } tws_ctl_t;

endpackage

[hw/rtl/tws_wh_div.sv]
module tws_wh_div
  import tws_pkg::*;
#(
  parameter int TEX_SIZE = TexSizeDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        in_valid_i,
  input  tws_in_t     in_req_i,
  input  logic [31:0] proj_i,
  output logic        out_valid_o,
  output tws_in_t     out_req_o,
  output logic [31:0] out_wh_o
);

  localparam int Lt = $clog2(TEX_SIZE);
  localparam int Steps = 32;

  // numerator is proj * TEX_SIZE * 2^16
  logic [63:0] num;
  logic        sat_d;

  assign num   = {32'b0, proj_i} << (Lt + 16);
  assign sat_d = (in_req_i.wall_distance == 32'd0) ||
                 (num >= {in_req_i.wall_distance, 32'b0});

  logic [Steps:0] vld_q;
  logic [Steps:0] sat_q;
  tws_in_t        req_q [Steps+1];
  logic [31:0]    rem_q [Steps+1];
  logic [31:0]    quo_q [Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_q[0] <= in_req_i;
      sat_q[0] <= sat_d;
      rem_q[0] <= num[63:32];
      quo_q[0] <= '0;
    end
  end

  for (genvar s = 1; s <= Steps; s++) begin : g_step
    logic [32:0] trial;
    logic [32:0] diff;
    assign trial = {rem_q[s-1], num[Steps-s]};
    assign diff  = trial - {1'b0, req_q[s-1].wall_distance};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        req_q[s] <= req_q[s-1];
        sat_q[s] <= sat_q[s-1];
        rem_q[s] <= diff[32] ? trial[31:0] : diff[31:0];
        quo_q[s] <= {quo_q[s-1][30:0], ~diff[32]};
      end
    end
  end

  assign out_valid_o = vld_q[Steps];
  assign out_req_o   = req_q[Steps];
  assign out_wh_o    = sat_q[Steps] ? '1 : quo_q[Steps];

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Steps] && !sat_q[Steps] |-> rem_q[Steps] < req_q[Steps].wall_distance)
    else $error("wall height remainder not below distance");

endmodule

[hw/rtl/tws_geom.sv]
module tws_geom
  import tws_pkg::*;
#(
  parameter int TEX_SIZE = TexSizeDef,
  parameter int MAX_ROWS = MaxRowsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         in_valid_i,
  input  tws_in_t                      in_req_i,
  input  logic [31:0]                  in_wh_i,
  input  logic [10:0]                  screen_height_i,
  output logic                         out_valid_o,
  output tws_in_t                      out_req_o,
  output tws_ctl_t                     out_ctl_o,
  output logic [$clog2(TEX_SIZE)-1:0]  out_trow_o
);

  localparam int Lt = $clog2(TEX_SIZE);

  // stage 1: slice bounds in 1/2^17 row units
  logic [9:0]  hh;
  logic [35:0] start_raw;
  logic [27:0] start_d;
  logic [33:0] end_d;
  logic [15:0] ceil_d;
  logic [17:0] dft_d;
  logic [12:0] rows;
  logic        keep_d;

  assign hh        = screen_height_i[10:1];
  assign start_raw = {9'b0, hh, 17'b0} + 36'd131072 - {4'b0, in_wh_i};
  assign start_d   = start_raw[35] ? '0 : start_raw[27:0];
  assign end_d     = {7'b0, hh, 17'b0} + {2'b0, in_wh_i};
  assign ceil_d    = {6'b0, hh} + {1'b0, in_wh_i[31:17]} + {15'b0, |in_wh_i[16:0]};
  assign dft_d     = {8'b0, in_req_i.pixel_row} - {8'b0, hh} + {3'b0, in_wh_i[31:17]};
  assign rows      = ({2'b0, screen_height_i} < 13'(MAX_ROWS)) ? {2'b0, screen_height_i}
                                                               : 13'(MAX_ROWS);
  assign keep_d    = {3'b0, in_req_i.pixel_row} < rows;

  logic        g1_vld_q;
  tws_in_t     g1_req_q;
  logic [31:0] g1_wh_q;
  logic [27:0] g1_start_q;
  logic [33:0] g1_end_q;
  logic [15:0] g1_ceil_q;
  logic [17:0] g1_dft_q;
  logic        g1_keep_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g1_req_q   <= in_req_i;
      g1_wh_q    <= in_wh_i;
      g1_start_q <= start_d;
      g1_end_q   <= end_d;
      g1_ceil_q  <= ceil_d;
      g1_dft_q   <= dft_d;
      g1_keep_q  <= keep_d;
    end
  end

  // stage 2: last wall row, top test, texture row mode
  logic [10:0] s0;
  logic        empty;
  logic [15:0] end_row;
  logic [15:0] last_d;
  logic        top_d;
  logic        dft_pos_d;
  logic        clamp_d;

  assign s0        = g1_start_q[27:17];
  assign empty     = (s0 >= screen_height_i) || ({6'b0, s0, 17'b0} >= g1_end_q);
  assign end_row   = (g1_ceil_q > {5'b0, screen_height_i}) ? {5'b0, screen_height_i}
                                                           : g1_ceil_q;
  assign last_d    = empty ? {5'b0, s0} : end_row;
  assign top_d     = {1'b0, g1_req_q.pixel_row, 17'b0} < g1_start_q;
  assign dft_pos_d = !g1_dft_q[17] && (g1_dft_q != '0);
  assign clamp_d   = {g1_dft_q[16:0], 16'b0} >= {1'b0, g1_wh_q};

  logic        g2_vld_q;
  tws_in_t     g2_req_q;
  logic [31:0] g2_wh_q;
  logic [15:0] g2_last_q;
  logic        g2_top_q;
  logic        g2_dft_pos_q;
  logic        g2_clamp_q;
  logic [15:0] g2_dft_q;
  logic        g2_keep_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      g2_req_q     <= g1_req_q;
      g2_wh_q      <= g1_wh_q;
      g2_last_q    <= last_d;
      g2_top_q     <= top_d;
      g2_dft_pos_q <= dft_pos_d;
      g2_clamp_q   <= clamp_d;
      g2_dft_q     <= g1_dft_q[15:0];
      g2_keep_q    <= g1_keep_q;
    end
  end

  // stage 3: classify the pixel, set up the texture row division
  tws_ctl_t ctl_d;
  logic     side_ok;

  assign side_ok = (g2_req_q.hit_side == SideHoriz) || (g2_req_q.hit_side == SideVert);

  always_comb begin
    ctl_d.keep = g2_keep_q;
    if ({6'b0, g2_req_q.pixel_row} >= g2_last_q) begin
      ctl_d.kind = PixBottom;
    end else if (g2_top_q) begin
      ctl_d.kind = PixTop;
    end else if (side_ok) begin
      ctl_d.kind = PixTexel;
    end else begin
      ctl_d.kind = PixBlack;
    end
    if (g2_req_q.hit_side == SideHoriz) begin
      ctl_d.tex_sel = g2_req_q.facing_positive ? TexNorth : TexSouth;
    end else begin
      ctl_d.tex_sel = g2_req_q.facing_positive ? TexEast : TexWest;
    end
  end

  logic [Lt:0] vld_q;
  logic [Lt:0] zero_q;
  logic [Lt:0] max_q;
  tws_in_t     req_q [Lt+1];
  tws_ctl_t    ctl_q [Lt+1];
  logic [31:0] wh_q  [Lt+1];
  logic [31:0] rem_q [Lt+1];
  logic [Lt-1:0] quo_q [Lt+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_vld_q <= 1'b0;
      g2_vld_q <= 1'b0;
      vld_q    <= '0;
    end else if (en_i) begin
      g1_vld_q <= in_valid_i;
      g2_vld_q <= g1_vld_q;
      vld_q    <= {vld_q[Lt-1:0], g2_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_q[0]  <= g2_req_q;
      ctl_q[0]  <= ctl_d;
      wh_q[0]   <= g2_wh_q;
      rem_q[0]  <= {g2_dft_q, 16'b0};
      quo_q[0]  <= '0;
      zero_q[0] <= !g2_dft_pos_q || (g2_wh_q == '0);
      max_q[0]  <= g2_clamp_q;
    end
  end

  for (genvar s = 1; s <= Lt; s++) begin : g_step
    logic [32:0] trial;
    logic [32:0] diff;
    assign trial = {rem_q[s-1], 1'b0};
    assign diff  = trial - {1'b0, wh_q[s-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        req_q[s]  <= req_q[s-1];
        ctl_q[s]  <= ctl_q[s-1];
        wh_q[s]   <= wh_q[s-1];
        zero_q[s] <= zero_q[s-1];
        max_q[s]  <= max_q[s-1];
        rem_q[s]  <= diff[32] ? trial[31:0] : diff[31:0];
        quo_q[s]  <= {quo_q[s-1][Lt-2:0], ~diff[32]};
      end
    end
  end

  assign out_valid_o = vld_q[Lt];
  assign out_req_o   = req_q[Lt];
  assign out_ctl_o   = ctl_q[Lt];
  assign out_trow_o  = zero_q[Lt] ? '0 : (max_q[Lt] ? '1 : quo_q[Lt]);

  a_trow_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !zero_q[0] && !max_q[0] |-> rem_q[0] < wh_q[0])
    else $error("texture row division would overflow");

endmodule

[hw/rtl/tws_tex_mem.sv]
module tws_tex_mem
  import tws_pkg::*;
#(
  parameter int TEX_SIZE = TexSizeDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         in_valid_i,
  input  tws_in_t                      in_req_i,
  input  tws_ctl_t                     in_ctl_i,
  input  logic [$clog2(TEX_SIZE)-1:0]  in_trow_i,
  input  logic [31:0]                  top_colour_i,
  input  logic [31:0]                  bottom_colour_i,
  output logic                         out_valid_o,
  output tws_out_t                     out_req_o
);

  localparam int Lt = $clog2(TEX_SIZE);
  localparam int AreaW = 2 * Lt;
  localparam int AddrW = TexSelW + AreaW;
  localparam int Depth = NumTextures * TEX_SIZE * TEX_SIZE;

  logic [31:0] mem [Depth];

  // texel address wraps inside one texture
  logic [AreaW+11:0] waddr_ext;
  logic [AddrW-1:0]  addr;
  logic              we;

  assign waddr_ext = {{AreaW{1'b0}}, in_req_i.texel_address};
  assign addr = in_req_i.func ?
                {in_ctl_i.tex_sel, in_trow_i, in_req_i.hit_coordinate[Lt-1:0]} :
                {in_req_i.texture_select, waddr_ext[AreaW-1:0]};
  assign we   = in_valid_i && !in_req_i.func;

  logic [31:0] rd_q;
  logic        vld_q;
  logic [9:0]  row_q;
  logic [9:0]  col_q;
  tws_pix_e    kind_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we) begin
        mem[addr] <= in_req_i.texel_colour;
      end
      rd_q   <= mem[addr];
      row_q  <= in_req_i.pixel_row;
      col_q  <= in_req_i.pixel_column;
      kind_q <= in_ctl_i.kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= in_valid_i && in_req_i.func && in_ctl_i.keep;
    end
  end

  always_comb begin
    out_req_o.out_row    = row_q;
    out_req_o.out_column = col_q;
    case (kind_q)
      PixTop:    out_req_o.pixel_colour = top_colour_i;
      PixBottom: out_req_o.pixel_colour = bottom_colour_i;
      PixTexel:  out_req_o.pixel_colour = rd_q;
      default:   out_req_o.pixel_colour = '0;
    endcase
  end

  assign out_valid_o = vld_q;

endmodule

[hw/rtl/textured_wall_column_shader_core.sv]
// channel | dir | handshake                 | payload
// in      | in  | in_valid_i / in_stall_o   | in_req_i (tws_in_t)
// out     | out | out_valid_o / out_stall_i | out_req_o (tws_out_t)
// cfg     | in  | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// one request per cycle while no result is held under out_stall_i; 37 + log2(TEX_SIZE) register stages (43 at 64),
// set by the 32-step wall height divider plus the texture row divider
// texel writes flow down the same pipe, so writes and reads hit the store in order
// rst_ni is asynchronous, active low; it clears valid bits and resets config, not the store
// the whole pipe holds while a result waits under out_stall_i
module textured_wall_column_shader_core
  import tws_pkg::*;
#(
  parameter int TEX_SIZE = TexSizeDef,
  parameter int MAX_ROWS = MaxRowsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  tws_in_t     in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output tws_out_t    out_req_o,
  input  logic        cfg_we_i,
  input  tws_reg_e    cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int Lt = $clog2(TEX_SIZE);

  // config registers
  logic [10:0] screen_height_q;
  logic [31:0] projection_q;
  logic [31:0] top_colour_q;
  logic [31:0] bottom_colour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_height_q <= 11'(ScreenHeightRst);
      projection_q    <= 32'(ProjectionRst);
      top_colour_q    <= '0;
      bottom_colour_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegScreenHeight: screen_height_q <= cfg_data_i[10:0];
        RegProjection:   projection_q    <= cfg_data_i;
        RegTopColour:    top_colour_q    <= cfg_data_i;
        RegBottomColour: bottom_colour_q <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  // global advance: everything moves unless a result is held
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic        div_valid;
  tws_in_t     div_req;
  logic [31:0] div_wh;

  // wall height = TEX_SIZE * projection / distance, saturating
  tws_wh_div #(
    .TEX_SIZE (TEX_SIZE)
  ) u_wh_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .proj_i      (projection_q),
    .out_valid_o (div_valid),
    .out_req_o   (div_req),
    .out_wh_o    (div_wh)
  );

  logic          geo_valid;
  tws_in_t       geo_req;
  tws_ctl_t      geo_ctl;
  logic [Lt-1:0] geo_trow;

  // slice bounds, pixel class and texture row
  tws_geom #(
    .TEX_SIZE (TEX_SIZE),
    .MAX_ROWS (MAX_ROWS)
  ) u_geom (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .in_valid_i      (div_valid),
    .in_req_i        (div_req),
    .in_wh_i         (div_wh),
    .screen_height_i (screen_height_q),
    .out_valid_o     (geo_valid),
    .out_req_o       (geo_req),
    .out_ctl_o       (geo_ctl),
    .out_trow_o      (geo_trow)
  );

  // texture store access and final colour pick
  tws_tex_mem #(
    .TEX_SIZE (TEX_SIZE)
  ) u_tex_mem (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .in_valid_i      (geo_valid),
    .in_req_i        (geo_req),
    .in_ctl_i        (geo_ctl),
    .in_trow_i       (geo_trow),
    .top_colour_i    (top_colour_q),
    .bottom_colour_i (bottom_colour_q),
    .out_valid_o     (out_valid_o),
    .out_req_o       (out_req_o)
  );

  // only on-screen rows come out
  a_row_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {1'b0, out_req_o.out_row} < screen_height_q)
    else $error("result row beyond screen height");

  // intake stops only while a result is held
  a_stall_only_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("intake stalled without a held result");

endmodule

[tb/tb_textured_wall_column_shader_core.sv]
module tb_textured_wall_column_shader_core;
  import tws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TexArea  = TexSizeDef * TexSizeDef;
  localparam int Depth    = NumTextures * TexArea;
  // pipe depth from the port-list note, plus margin for the idle windows
  localparam int Latency  = 43;
  localparam int IdleWait = Latency + 20;
  localparam int LongHold = 300;
  localparam int DogLimit = 3000;

  // keeps its own copy of the registers and texture store, predicts pixels in order
  class shade_scoreboard;
    logic [31:0] texels [Depth];
    bit          written [Depth];
    logic [10:0] scr_h = 11'(ScreenHeightRst);
    logic [31:0] proj = ProjectionRst;
    logic [31:0] top_c = '0;
    logic [31:0] bot_c = '0;
    tws_out_t    pixels_due [$];
    int          errors = 0;

    function bit on_screen(tws_in_t r);
      int rows;
      rows = (scr_h < MaxRowsDef) ? scr_h : MaxRowsDef;
      return r.pixel_row < rows;
    endfunction

    // store slot the pixel reads, or -1 when its colour is flat
    function int texel_slot(tws_in_t r, output logic [31:0] flat);
      longint unsigned num, q, trow;
      logic [31:0] wh;
      longint hh2, w2, start2, end2, s0, last, r2, dft;
      logic [1:0] sel;
      if (r.wall_distance == 0) wh = '1;
      else begin
        num = (longint'(TexSizeDef) * proj) << 16;
        q = num / r.wall_distance;
        wh = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      end
      hh2 = longint'(scr_h / 2) << 17;
      w2 = longint'(wh);
      start2 = hh2 - w2 + (64'sd1 << 17);
      if (start2 < 0) start2 = 0;
      end2 = hh2 + w2;
      s0 = start2 >> 17;
      if (s0 >= scr_h || (s0 << 17) >= end2) last = s0;
      else begin
        last = (end2 + (64'sd1 << 17) - 1) >> 17;
        if (last > scr_h) last = scr_h;
      end
      r2 = longint'(r.pixel_row) << 17;
      flat = '0;
      if (r.pixel_row >= last) begin
        flat = bot_c;
        return -1;
      end
      if (r2 < start2) begin
        flat = top_c;
        return -1;
      end
      // no side means black inside the slice
      if (r.hit_side == SideHoriz) sel = r.facing_positive ? TexNorth : TexSouth;
      else if (r.hit_side == SideVert) sel = r.facing_positive ? TexEast : TexWest;
      else return -1;
      dft = (r2 + w2 - hh2) >>> 17;
      trow = 0;
      if (dft > 0 && wh != 0) trow = ((longint'(dft) * TexSizeDef) << 16) / wh;
      if (trow > TexSizeDef - 1) trow = TexSizeDef - 1;
      return sel * TexArea + int'(trow) * TexSizeDef + (r.hit_coordinate % TexSizeDef);
    endfunction

    function void note_request(tws_in_t r);
      int slot;
      logic [31:0] flat;
      tws_out_t px;
      if (!r.func) begin
        slot = r.texture_select * TexArea + (r.texel_address % TexArea);
        texels[slot] = r.texel_colour;
        written[slot] = 1'b1;
        return;
      end
      if (!on_screen(r)) return;
      slot = texel_slot(r, flat);
      px.out_row = r.pixel_row;
      px.out_column = r.pixel_column;
      px.pixel_colour = (slot < 0) ? flat : texels[slot];
      pixels_due.push_back(px);
    endfunction

    function void check_result(tws_out_t got);
      tws_out_t want;
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel row %0d col %0d", got.out_row, got.out_column);
        errors++;
        return;
      end
      want = pixels_due.pop_front();
      if (got.out_row !== want.out_row) begin
        $error("out_row exp %0d got %0d", want.out_row, got.out_row);
        errors++;
      end
      if (got.out_column !== want.out_column) begin
        $error("out_column exp %0d got %0d", want.out_column, got.out_column);
        errors++;
      end
      if (got.pixel_colour !== want.pixel_colour) begin
        $error("pixel_colour exp %h got %h", want.pixel_colour, got.pixel_colour);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  tws_in_t     in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  tws_out_t    out_req;
  logic        cfg_we = 1'b0;
  tws_reg_e    cfg_index = RegScreenHeight;
  logic [31:0] cfg_data = '0;

  shade_scoreboard sb = new();
  bit no_idle = 1'b0;    // both sides run flat out
  bit hold_pending = 1'b0;
  int quiet_cycles = 0;

  textured_wall_column_shader_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: check every accepted pixel against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_req);
  end

  // receiver stalls: random per pixel, once a long hold so the pipe backs up
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 18);
      if (hold_pending) begin
        n = LongHold;
        hold_pending = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  // watchdog on cycles with no handshake on either side and no config write
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == DogLimit) begin
      $display("[textured_wall_column_shader_core] ERROR");
      $finish;
    end
  end

  task automatic offer(tws_in_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk_i); while (in_stall);
    sb.note_request(r);
  endtask

  // a pixel that lands on a never-written texel gets that texel written first
  task automatic shade(tws_in_t r);
    tws_in_t w;
    logic [31:0] flat;
    int slot;
    if (r.func && sb.on_screen(r)) begin
      slot = sb.texel_slot(r, flat);
      if (slot >= 0 && !sb.written[slot]) begin
        w = r;
        w.func = 1'b0;
        w.texture_select = 2'(slot / TexArea);
        w.texel_address = 12'(slot % TexArea);
        w.texel_colour = $urandom;
        offer(w);
      end
    end
    offer(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pixels_due.size() > 0) @(posedge clk_i);
    repeat (IdleWait) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] h, logic [31:0] p, logic [31:0] t, logic [31:0] b);
    cfg_we <= 1'b1;
    cfg_index <= RegScreenHeight;
    cfg_data <= h;
    @(posedge clk_i);
    cfg_index <= RegProjection;
    cfg_data <= p;
    @(posedge clk_i);
    cfg_index <= RegTopColour;
    cfg_data <= t;
    @(posedge clk_i);
    cfg_index <= RegBottomColour;
    cfg_data <= b;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.scr_h = h[10:0];
    sb.proj = p;
    sb.top_c = t;
    sb.bot_c = b;
  endtask

  function automatic tws_in_t any_req();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(tws_in_t)-1:0];
  endfunction

  function automatic tws_in_t pix(int row, logic [31:0] wall_dist, logic [1:0] side, bit face,
                                  logic [15:0] coord);
    tws_in_t r;
    r = any_req();
    r.func = 1'b1;
    r.pixel_row = 10'(row);
    r.wall_distance = wall_dist;
    r.hit_side = side;
    r.facing_positive = face;
    r.hit_coordinate = coord;
    return r;
  endfunction

  function automatic tws_in_t rand_req();
    tws_in_t r;
    int rows;
    r = any_req();
    if ($urandom_range(0, 3) == 0) begin
      r.func = 1'b0;
      return r;
    end
    r.func = 1'b1;
    rows = (sb.scr_h < MaxRowsDef) ? sb.scr_h : MaxRowsDef;
    if (rows > 0 && $urandom_range(0, 9) != 0) r.pixel_row = 10'($urandom_range(0, rows - 1));
    case ($urandom_range(0, 9))
      0: r.wall_distance = 0;
      1: r.wall_distance = 1;
      2: r.wall_distance = '1;
      3, 4: ;
      default: r.wall_distance = ($urandom >> $urandom_range(8, 31)) | 1;
    endcase
    if ($urandom_range(0, 7) != 0) r.hit_side = 2'($urandom_range(SideHoriz, SideVert));
    return r;
  endfunction

  task automatic random_phase(int n);
    repeat (n) shade(rand_req());
    drain();
  endtask

  initial begin
    tws_in_t r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corner texels, off-screen rows, distance extremes, every side
    write_regs(ScreenHeightRst, ProjectionRst, 32'h1111_1111, 32'h2222_2222);
    for (int t = 0; t < NumTextures; t++) begin
      r = any_req();
      r.func = 1'b0;
      r.texture_select = 2'(t);
      r.texel_address = (t % 2) ? 12'hFFF : 12'h000;
      r.texel_colour = (t % 2) ? 32'hFFFF_FFFF : 32'h0;
      offer(r);
    end
    shade(pix(0, 32'h0, SideHoriz, 1'b1, 16'h0000));
    shade(pix(479, 32'h0, SideHoriz, 1'b0, 16'hFFFF));
    shade(pix(480, 32'h1_0000, SideVert, 1'b1, 16'h0001));
    shade(pix(1023, 32'h1_0000, SideVert, 1'b0, 16'h0003));
    shade(pix(0, 32'hFFFF_FFFF, SideHoriz, 1'b1, 16'h0010));
    shade(pix(479, 32'hFFFF_FFFF, SideVert, 1'b1, 16'h0020));
    shade(pix(240, 32'h0001, SideVert, 1'b0, 16'h003F));
    for (int s = 0; s < 4; s++) begin
      shade(pix(240, 32'h40_0000, 2'(s), 1'b1, 16'h1234));
      shade(pix(200, 32'h40_0000, 2'(s), 1'b0, 16'h4321));
    end
    shade(pix(10, 32'h40_0000, SideHoriz, 1'b1, 16'h0));
    shade(pix(470, 32'h40_0000, SideHoriz, 1'b1, 16'h0));
    drain();

    // random phases over several register settings, extremes included
    write_regs(1, '1, $urandom, $urandom);
    random_phase(150);
    write_regs(1024, ProjectionRst, $urandom, $urandom);
    random_phase(250);
    write_regs(0, $urandom, $urandom, $urandom);
    random_phase(60);
    write_regs(2047, 0, '1, 0);
    random_phase(150);

    // back-to-back traffic with one long receiver hold to fill the pipe
    write_regs(ScreenHeightRst, ProjectionRst, $urandom, $urandom);
    no_idle = 1'b1;
    hold_pending = 1'b1;
    random_phase(300);
    no_idle = 1'b0;

    write_regs($urandom_range(1, 1024), $urandom, $urandom, $urandom);
    random_phase(250);
    write_regs($urandom_range(1, 1024), $urandom >> $urandom_range(0, 12), $urandom, $urandom);
    random_phase(300);

    if (sb.errors == 0 && sb.pixels_due.size() == 0) begin
      $display("[textured_wall_column_shader_core] OK");
    end else begin
      $display("[textured_wall_column_shader_core] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tws_pkg.sv
hw/rtl/tws_wh_div.sv
hw/rtl/tws_geom.sv
hw/rtl/tws_tex_mem.sv
hw/rtl/textured_wall_column_shader_core.sv
tb/tb_textured_wall_column_shader_core.sv
